// ===== hdl/kfi_pkg.sv =====
// ----------------------------------------------------------------------------
// kfi_pkg
// Shared types and constants of the keyframe position interpolator.
// ----------------------------------------------------------------------------
package kfi_pkg;

  localparam int MAX_KEYS = 64;
  localparam int AW       = $clog2(MAX_KEYS);
  localparam int PTR_W    = $clog2(MAX_KEYS + 1);
  localparam int KC_W     = 7;
  localparam int T_W      = 32;
  localparam int P_W      = 32;
  localparam int DIFF_W   = T_W + 1;
  localparam int FRAC_W   = 16;
  localparam int Q_W      = DIFF_W + FRAC_W;
  localparam int PROD_W   = DIFF_W + Q_W;
  localparam int MAG_W    = PROD_W - FRAC_W;
  localparam int SUM_W    = MAG_W + 2;
  localparam int STEP_W   = $clog2(Q_W);
  localparam int LANES    = 3;
  localparam int ROW_W    = T_W + LANES * P_W;

  localparam logic       OP_WRITE  = 1'b0;
  localparam logic       OP_SAMPLE = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_SAT   = 2'd1;
  localparam logic [1:0] STATUS_ZSPAN = 2'd2;

  typedef struct packed {
    logic               operation;
    logic [5:0]         key_index;
    logic [31:0]        key_time;
    logic signed [31:0] key_x;
    logic signed [31:0] key_y;
    logic signed [31:0] key_z;
    logic [31:0]        sample_time;
  } kfi_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [5:0]         segment_start;
    logic [1:0]         status;
  } kfi_out_t;

  typedef struct packed {
    logic [T_W-1:0]            t;
    logic [LANES-1:0][P_W-1:0] p;
  } kfi_row_t;

  typedef enum logic [1:0] {
    RD_PTR,
    RD_SEG,
    RD_NEXT
  } kfi_rd_sel_e;

  typedef struct packed {
    logic        accept;
    logic        ptr_step;
    kfi_rd_sel_e rd_sel;
    logic        seg_set;
    logic        cap0;
    logic        cap1;
    logic        prep;
    logic        div_step;
    logic        mul_load;
    logic        mul_step;
    logic        rnd;
    logic        fin;
  } kfi_cmd_t;

  typedef struct packed {
    logic single;
    logic hit;
    logic last;
    logic span_zero;
  } kfi_stat_t;

endpackage

// ===== hdl/kfi_ram.sv =====
// ----------------------------------------------------------------------------
// kfi_ram
// Generic simple dual-port RAM, one write port, registered read.
// ----------------------------------------------------------------------------
module kfi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/kfi_datapath.sv =====
// ----------------------------------------------------------------------------
// kfi_datapath
// Key table, segment search pointer, serial divider and three serial
// multipliers with rounding and saturation.
// ----------------------------------------------------------------------------
module kfi_datapath import kfi_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [KC_W-1:0] cfg_data_i,
  input  logic            wr_en_i,
  input  kfi_in_t         in_i,
  input  kfi_cmd_t        cmd_i,
  output kfi_stat_t       stat_o,
  output logic            result_strobe_o,
  output kfi_out_t        result_o
);

  logic [KC_W-1:0]   key_count_q;
  logic [T_W-1:0]    st_q;
  logic [PTR_W-1:0]  n_q, n_d;
  logic [PTR_W-1:0]  ptr_q;
  logic [AW-1:0]     seg_q;
  logic [AW-1:0]     raddr;
  kfi_row_t          wrow, rrow, row0_q, row1_q;
  logic [DIFF_W-1:0] span, num, span_abs, num_abs;
  logic              fneg;
  logic              zspan_q;
  logic [Q_W-1:0]    dvd_q;
  logic [DIFF_W-1:0] dvs_q;
  logic [DIFF_W-1:0] rem_q;
  logic [DIFF_W:0]   r2, r2_sub;
  logic              ge;
  logic [LANES-1:0][DIFF_W-1:0] ad_q;
  logic [LANES-1:0]             neg_q;
  logic [LANES-1:0][PROD_W-1:0] prod_q;
  logic [LANES-1:0][DIFF_W-1:0] dlt, dlt_abs;
  logic [LANES-1:0][DIFF_W:0]   hi;
  logic [LANES-1:0][SUM_W-1:0]  p0s, magw, sum;
  logic [LANES-1:0][P_W-1:0]    pos;
  logic [LANES-1:0]             sat;
  logic                         valid_q;
  kfi_out_t                     result_q;

  always_comb begin
    if (key_count_q == '0) begin
      n_d = PTR_W'(1);
    end else if (32'(key_count_q) > MAX_KEYS) begin
      n_d = PTR_W'(MAX_KEYS);
    end else begin
      n_d = PTR_W'(key_count_q);
    end
  end

  assign wrow.t    = in_i.key_time;
  assign wrow.p[0] = in_i.key_x;
  assign wrow.p[1] = in_i.key_y;
  assign wrow.p[2] = in_i.key_z;

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_PTR:  raddr = ptr_q[AW-1:0];
      RD_SEG:  raddr = seg_q;
      RD_NEXT: raddr = seg_q + AW'(1);
      default: raddr = seg_q;
    endcase
  end

  kfi_ram #(
    .WIDTH(ROW_W),
    .DEPTH(MAX_KEYS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en_i),
    .waddr_i(in_i.key_index[AW-1:0]),
    .wdata_i(wrow),
    .raddr_i(raddr),
    .rdata_o(rrow)
  );

  assign span     = {1'b0, row1_q.t} - {1'b0, row0_q.t};
  assign num      = {1'b0, st_q} - {1'b0, row0_q.t};
  assign span_abs = span[DIFF_W-1] ? -span : span;
  assign num_abs  = num[DIFF_W-1] ? -num : num;
  assign fneg     = span[DIFF_W-1] ^ num[DIFF_W-1];

  assign r2     = {rem_q, dvd_q[Q_W-1]};
  assign ge     = r2 >= {1'b0, dvs_q};
  assign r2_sub = r2 - {1'b0, dvs_q};

  always_comb begin
    for (int a = 0; a < LANES; a++) begin
      dlt[a]     = {row1_q.p[a][P_W-1], row1_q.p[a]} - {row0_q.p[a][P_W-1], row0_q.p[a]};
      dlt_abs[a] = dlt[a][DIFF_W-1] ? -dlt[a] : dlt[a];
      hi[a]      = {1'b0, prod_q[a][PROD_W-1:Q_W]}
                 + (prod_q[a][0] ? {1'b0, ad_q[a]} : '0);
      p0s[a]     = {{(SUM_W-P_W){row0_q.p[a][P_W-1]}}, row0_q.p[a]};
      magw[a]    = {2'b00, prod_q[a][PROD_W-1:FRAC_W]};
      sum[a]     = neg_q[a] ? p0s[a] - magw[a] : p0s[a] + magw[a];
      if (!sum[a][SUM_W-1] && (sum[a][SUM_W-2:P_W-1] != '0)) begin
        sat[a] = 1'b1;
        pos[a] = {1'b0, {(P_W-1){1'b1}}};
      end else if (sum[a][SUM_W-1] && (sum[a][SUM_W-2:P_W-1] != '1)) begin
        sat[a] = 1'b1;
        pos[a] = {1'b1, {(P_W-1){1'b0}}};
      end else begin
        sat[a] = 1'b0;
        pos[a] = sum[a][P_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= KC_W'(1);
      valid_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        key_count_q <= cfg_data_i;
      end
      valid_q <= cmd_i.fin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      st_q    <= in_i.sample_time;
      n_q     <= n_d;
      ptr_q   <= PTR_W'(1);
      seg_q   <= '0;
      zspan_q <= 1'b0;
      prod_q  <= '0;
    end
    if (cmd_i.ptr_step) begin
      ptr_q <= ptr_q + PTR_W'(1);
    end
    if (cmd_i.seg_set) begin
      seg_q <= AW'(ptr_q - PTR_W'(2));
    end
    if (cmd_i.cap0) begin
      row0_q <= rrow;
    end
    if (cmd_i.cap1) begin
      row1_q <= rrow;
    end
    if (cmd_i.prep) begin
      zspan_q <= (span == '0);
      dvd_q   <= {num_abs, {FRAC_W{1'b0}}};
      dvs_q   <= span_abs;
      rem_q   <= '0;
      for (int a = 0; a < LANES; a++) begin
        ad_q[a]  <= dlt_abs[a];
        neg_q[a] <= dlt[a][DIFF_W-1] ^ fneg;
      end
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? r2_sub[DIFF_W-1:0] : r2[DIFF_W-1:0];
      dvd_q <= {dvd_q[Q_W-2:0], ge};
    end
    for (int a = 0; a < LANES; a++) begin
      if (cmd_i.mul_load) begin
        prod_q[a] <= {{DIFF_W{1'b0}}, dvd_q};
      end else if (cmd_i.mul_step) begin
        prod_q[a] <= {hi[a], prod_q[a][Q_W-1:1]};
      end else if (cmd_i.rnd) begin
        prod_q[a] <= prod_q[a] + PROD_W'(1 << (FRAC_W - 1));
      end
    end
    if (cmd_i.fin) begin
      result_q.pos_x         <= pos[0];
      result_q.pos_y         <= pos[1];
      result_q.pos_z         <= pos[2];
      result_q.segment_start <= 6'(seg_q);
      if (zspan_q) begin
        result_q.status <= STATUS_ZSPAN;
      end else if (|sat) begin
        result_q.status <= STATUS_SAT;
      end else begin
        result_q.status <= STATUS_OK;
      end
    end
  end

  assign stat_o.single    = (n_q == PTR_W'(1));
  assign stat_o.hit       = st_q < rrow.t;
  assign stat_o.last      = (ptr_q == n_q);
  assign stat_o.span_zero = (span == '0);

  assign result_strobe_o = valid_q;
  assign result_o        = result_q;

endmodule

// ===== hdl/kfi_ctrl.sv =====
// ----------------------------------------------------------------------------
// kfi_ctrl
// Sequencer: key search, key fetch, divide, multiply, round and result.
// ----------------------------------------------------------------------------
module kfi_ctrl import kfi_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  logic      operation_i,
  input  kfi_stat_t stat_i,
  output logic      busy,
  output logic      wr_en_o,
  output kfi_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK,
    S_SRCH,
    S_RD0,
    S_RD1,
    S_CAP1,
    S_PREP,
    S_DIV,
    S_MLOAD,
    S_MUL,
    S_RND,
    S_FIN
  } state_e;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              take;

  assign busy    = (state_q != S_IDLE);
  assign take    = start && !busy;
  assign wr_en_o = take && (operation_i == OP_WRITE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.rd_sel = RD_PTR;
    unique case (state_q)
      S_IDLE: begin
        if (take && (operation_i == OP_SAMPLE)) begin
          cmd_o.accept = 1'b1;
          state_d      = S_CHK;
        end
      end
      S_CHK: begin
        if (stat_i.single) begin
          state_d = S_RD0;
        end else begin
          cmd_o.ptr_step = 1'b1;
          state_d        = S_SRCH;
        end
      end
      S_SRCH: begin
        priority if (stat_i.hit) begin
          cmd_o.seg_set = 1'b1;
          state_d       = S_RD0;
        end else if (stat_i.last) begin
          state_d = S_RD0;
        end else begin
          cmd_o.ptr_step = 1'b1;
        end
      end
      S_RD0: begin
        cmd_o.rd_sel = RD_SEG;
        state_d      = S_RD1;
      end
      S_RD1: begin
        cmd_o.rd_sel = RD_NEXT;
        cmd_o.cap0   = 1'b1;
        state_d      = S_CAP1;
      end
      S_CAP1: begin
        cmd_o.cap1 = 1'b1;
        state_d    = stat_i.single ? S_RND : S_PREP;
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        cnt_d      = '0;
        state_d    = stat_i.span_zero ? S_RND : S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + STEP_W'(1);
        if (cnt_q == STEP_W'(Q_W - 1)) begin
          state_d = S_MLOAD;
        end
      end
      S_MLOAD: begin
        cmd_o.mul_load = 1'b1;
        cnt_d          = '0;
        state_d        = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        cnt_d          = cnt_q + STEP_W'(1);
        if (cnt_q == STEP_W'(Q_W - 1)) begin
          state_d = S_RND;
        end
      end
      S_RND: begin
        cmd_o.rnd = 1'b1;
        state_d   = S_FIN;
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== hdl/keyframe_position_interpolator.sv =====
// ----------------------------------------------------------------------------
// keyframe_position_interpolator
// Linear position interpolation over a table of up to 64 Q16.16 keys.
// ----------------------------------------------------------------------------
// A key write (operation 0) goes straight into the key table and busy stays low. A
// sample raises busy until its result is done; the result word appears on result_o
// with result_strobe_o high for a single cycle and cannot be held off. The segment
// search scans the keys with one table read per cycle, followed by a radix-2 divide
// and a shift-add multiply for all three axes at once. With one key in use, or with
// a zero time span, the divide and multiply are skipped. The configuration port is
// always ready; write it only while busy is low and no result is pending.
module keyframe_position_interpolator import kfi_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  kfi_in_t         in_i,
  output logic            result_strobe_o,
  output kfi_out_t        result_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [KC_W-1:0] cfg_data_i
);

  kfi_cmd_t  cmd;
  kfi_stat_t stat;
  logic      wr_en;

  assign cfg_ready_o = 1'b1;

  kfi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .operation_i(in_i.operation),
    .stat_i     (stat),
    .busy       (busy),
    .wr_en_o    (wr_en),
    .cmd_o      (cmd)
  );

  kfi_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .wr_en_i        (wr_en),
    .in_i           (in_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .result_strobe_o(result_strobe_o),
    .result_o       (result_o)
  );

endmodule

// ===== hdl/kfi_checker.sv =====
// ----------------------------------------------------------------------------
// kfi_checker
// Port-level checks of the interpolator, bound to the top level.
// ----------------------------------------------------------------------------
module kfi_checker import kfi_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            busy,
  input kfi_in_t         in_i,
  input logic            result_strobe_o,
  input kfi_out_t        result_o,
  input logic            cfg_valid_i,
  input logic            cfg_ready_o,
  input logic [KC_W-1:0] cfg_data_i
);

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> !busy)
    else $error("result word while busy");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |=> !result_strobe_o)
    else $error("result word longer than one cycle");

  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (in_i.operation == OP_SAMPLE)) |=> busy)
    else $error("sample taken without busy");

  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (in_i.operation == OP_WRITE)) |=> (!busy && !result_strobe_o))
    else $error("key write caused work or a result");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> (result_o.status == STATUS_OK || result_o.status == STATUS_SAT
                         || result_o.status == STATUS_ZSPAN))
    else $error("undefined status code");

endmodule

bind keyframe_position_interpolator kfi_checker u_kfi_checker (.*);
